// ===== src/sss_pkg.sv =====
// Package for the scoped symbol stack: default sizes, opcodes and status codes.
`timescale 1ns / 1ps
package sss_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int NAME_W   = 64;

  localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
  localparam logic [OP_W-1:0] OP_CP_GET     = 3'd1;
  localparam logic [OP_W-1:0] OP_CP_SET     = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd3;
  localparam logic [OP_W-1:0] OP_LAST_STACK = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

endpackage

// ===== src/scoped_symbol_stack.sv =====
// Top level of the scoped symbol stack: entry memory, search sequencer, result register.
`timescale 1ns / 1ps
// Usage:
// - Input channel (in_valid/in_ready) carries one command beat: opcode, name,
//   on-stack flag, payload and checkpoint. Result channel (out_valid/out_ready)
//   returns exactly one beat per command: status, search hit and the found
//   entry's fields, plus the entry count after the command.
// - Push, get checkpoint, set checkpoint and unknown opcodes finish in the
//   accept cycle; their result is registered and visible in the next cycle.
// - Find name and last on stack scan the entry memory from the top entry down,
//   one entry per cycle through the memory read port, until the first hit or
//   entry zero.
// - One command is in flight at a time. A new beat is taken as soon as the
//   block is idle and the result register is empty or being drained, so a
//   stalled receiver holds at most one result while the next command waits.
// - Reset (rst_n low, synchronous) empties the stack and drops any pending
//   result. Memory contents are not cleared; only entries below the count
//   are ever read.
module scoped_symbol_stack #(
  parameter int DEPTH        = sss_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = sss_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sss_pkg::OP_W-1:0]          in_opcode,
  input  logic [sss_pkg::NAME_W-1:0]        in_var_name,
  input  logic                              in_on_stack_flag,
  input  logic [PAYLOAD_BITS-1:0]           in_entry_payload,
  input  logic [$clog2(DEPTH+1)-1:0]        in_checkpoint,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sss_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_found,
  output logic [sss_pkg::NAME_W-1:0]        out_found_name,
  output logic                              out_found_on_stack,
  output logic [PAYLOAD_BITS-1:0]           out_found_payload,
  output logic [$clog2(DEPTH+1)-1:0]        out_count_now
);
  import sss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  typedef struct packed {
    logic [NAME_W-1:0]       name;
    logic                    flag;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // entry memory, one write port and one read port, registered read data
  entry_t mem [DEPTH];
  entry_t rd_r;

  logic              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              issued_last_r, issued_last_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [NAME_W-1:0] key_r, key_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [NAME_W-1:0]       out_name_r, out_name_nxt;
  logic                    out_flag_r, out_flag_nxt;
  logic [PAYLOAD_BITS-1:0] out_payload_r, out_payload_nxt;
  logic [CW-1:0]           out_count_r, out_count_nxt;

  logic   in_fire;
  logic   wr_en;
  entry_t wr_data;
  logic   hit;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign wr_data.name    = in_var_name;
  assign wr_data.flag    = in_on_stack_flag;
  assign wr_data.payload = in_entry_payload;

  // compare the entry read last cycle against the search criterion
  assign hit = rd_vld_r && ((op_r == OP_FIND) ? (rd_r.name == key_r) : rd_r.flag);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    addr_nxt        = addr_r;
    issued_last_nxt = issued_last_r;
    rd_vld_nxt      = 1'b0;
    rd_last_nxt     = rd_last_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    wr_en           = 1'b0;

    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_name_nxt    = out_name_r;
    out_flag_nxt    = out_flag_r;
    out_payload_nxt = out_payload_r;
    out_count_nxt   = out_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_status_nxt  = ST_OK;
          out_found_nxt   = 1'b0;
          out_name_nxt    = '0;
          out_flag_nxt    = 1'b0;
          out_payload_nxt = '0;
          out_valid_nxt   = 1'b1;
          unique case (in_opcode)
            OP_PUSH: begin
              if (count_r == FULL_CNT) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_CP_SET: begin
              if (in_checkpoint > count_r) begin
                out_status_nxt = ST_BEYOND;
              end else begin
                count_nxt = in_checkpoint;
              end
            end
            OP_FIND, OP_LAST_STACK: begin
              // empty stack: answer "not found" at once
              if (count_r != '0) begin
                out_valid_nxt   = 1'b0;
                state_nxt       = ST_SCAN;
                op_nxt          = in_opcode;
                key_nxt         = in_var_name;
                addr_nxt        = AW'(count_r - CW'(1));
                issued_last_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && (hit || rd_last_r)) begin
          // finish: result register is known empty during a scan
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_found_nxt   = hit;
          out_name_nxt    = hit ? rd_r.name : '0;
          out_flag_nxt    = hit ? rd_r.flag : 1'b0;
          out_payload_nxt = hit ? rd_r.payload : '0;
          out_count_nxt   = count_r;
        end else if (!issued_last_r) begin
          // issue the next read, walking down toward entry zero
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (addr_r == '0);
          if (addr_r == '0) begin
            issued_last_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r - AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      issued_last_r <= 1'b0;
      rd_vld_r      <= 1'b0;
      rd_last_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      issued_last_r <= issued_last_nxt;
      rd_vld_r      <= rd_vld_nxt;
      rd_last_r     <= rd_last_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    addr_r        <= addr_nxt;
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_name_r    <= out_name_nxt;
    out_flag_r    <= out_flag_nxt;
    out_payload_r <= out_payload_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found          = out_found_r;
  assign out_found_name     = out_name_r;
  assign out_found_on_stack = out_flag_r;
  assign out_found_payload  = out_payload_r;
  assign out_count_now      = out_count_r;

endmodule
